FILE: src/cmc_pkg.sv
package cmc_pkg;

  localparam int SLOTS_DEF = 4;
  localparam int COORD_W = 24;
  localparam int DIST_W = 52;
  localparam logic [DIST_W-1:0] DIST_RESET = 52'd3865470;
  // one slot entry: local xyz, world xyz, depth
  localparam int ENTRY_W = 7 * COORD_W;
  localparam int SCORE_W = 104;
  localparam int DIFF_W = 25;
  localparam int CROSS_W = 51;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;
  localparam logic [2:0] SLOT_NONE = 3'd4;

  typedef logic signed [COORD_W-1:0] coord_t;

  // sign-extended difference of two coordinates
  function automatic logic signed [DIFF_W-1:0] diff(input coord_t a, input coord_t b);
    diff = DIFF_W'(a) - DIFF_W'(b);
  endfunction

endpackage

FILE: src/cmc_ram.sv
module cmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/cmc_score.sv
module cmc_score (
  input  logic                          clk,
  input  logic                          start,
  input  cmc_pkg::coord_t               ux, uy, uz,
  input  cmc_pkg::coord_t               ax, ay, az,
  input  cmc_pkg::coord_t               bx, by, bz,
  input  cmc_pkg::coord_t               cx, cy, cz,
  output logic                          done,
  output logic [cmc_pkg::SCORE_W-1:0]   score
);
  import cmc_pkg::*;

  // pipeline: diffs, products, cross, magnitudes, partial squares, squares, sum
  logic signed [DIFF_W-1:0] u0, u1, u2, v0, v1, v2;
  logic signed [2*DIFF_W-1:0] p12, p21, p20, p02, p01, p10;
  logic signed [CROSS_W-1:0] w [3];
  // magnitude split into two 25-bit halves for the squaring
  logic [2:0][CROSS_W-2:0] mg;
  logic [2:0][2*DIFF_W-1:0] hh, hl, ll;
  logic [2:0][SCORE_W-4:0] sq;
  logic [6:0] vld;

  always_ff @(posedge clk) begin
    vld <= {vld[5:0], start};
    u0 <= diff(ux, ax);
    u1 <= diff(uy, ay);
    u2 <= diff(uz, az);
    v0 <= diff(cx, bx);
    v1 <= diff(cy, by);
    v2 <= diff(cz, bz);
    p12 <= u1 * v2;
    p21 <= u2 * v1;
    p20 <= u2 * v0;
    p02 <= u0 * v2;
    p01 <= u0 * v1;
    p10 <= u1 * v0;
    w[0] <= CROSS_W'(p12) - CROSS_W'(p21);
    w[1] <= CROSS_W'(p20) - CROSS_W'(p02);
    w[2] <= CROSS_W'(p01) - CROSS_W'(p10);
    for (int k = 0; k < 3; k++) begin
      mg[k] <= w[k][CROSS_W-1] ? (CROSS_W-1)'(-w[k]) : (CROSS_W-1)'(w[k]);
      hh[k] <= mg[k][2*DIFF_W-1:DIFF_W] * mg[k][2*DIFF_W-1:DIFF_W];
      hl[k] <= mg[k][2*DIFF_W-1:DIFF_W] * mg[k][DIFF_W-1:0];
      ll[k] <= mg[k][DIFF_W-1:0] * mg[k][DIFF_W-1:0];
      // hi^2 << 50 + 2*hi*lo << 25 + lo^2
      sq[k] <= (SCORE_W-3)'({hh[k], ll[k]}) + (SCORE_W-3)'({hl[k], (DIFF_W+1)'(0)});
    end
    score <= SCORE_W'(sq[0]) + SCORE_W'(sq[1]) + SCORE_W'(sq[2]);
  end

  assign done = vld[6];

endmodule

FILE: src/contact_manifold_cache.sv
// Contact manifold cache: keeps up to four contact points in a small slot
// RAM. One transfer in gives one transfer out. A clear resets the point
// count; an add reads the held slots one at a time through the single RAM
// read port for the distance test, and when the cache is full runs four
// cross-product scores through a 7-stage pipeline and then moves the last
// slot and writes the new point. The block takes one item at a time; the
// slot RAM needs no clearing after reset.
module contact_manifold_cache (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cmc_pkg::DIST_W-1:0]    cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata: local_x, local_y, local_z, world_x, world_y, world_z, pen_depth
  input  logic [7*cmc_pkg::COORD_W-1:0] s_tdata,
  // tuser: req_type
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata: stored, evicted_slot, point_count, zero fill
  output logic [7:0]                    m_tdata
);
  import cmc_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DUP_RD, S_DUP_CHK, S_DEPTH, S_SC_RD, S_SC_WAIT, S_MOVE_RD, S_MOVE_WR,
    S_APPEND, S_OUT
  } state_t;

  state_t state;
  logic [DIST_W-1:0] persist_dist_sq;
  logic [CW-1:0] held_count;
  logic [ENTRY_W-1:0] item;
  logic [AW-1:0] idx;
  logic [ENTRY_W-1:0] slots [SLOTS];
  logic signed [COORD_W-1:0] best;
  logic [2:0] prot;
  logic [SCORE_W-1:0] sc [SLOTS];
  logic [1:0] sc_idx;
  logic [2:0] evict;
  logic stored_r;

  // RAM port
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  cmc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // field views
  function automatic coord_t fld(input logic [ENTRY_W-1:0] e, input int k);
    fld = e[k*COORD_W +: COORD_W];
  endfunction

  // squared world distance of read entry to the new point
  logic [DIFF_W-1:0] dxa, dya, dza;
  logic [2*DIFF_W-1:0] qx, qy, qz;
  logic [DIST_W-1:0] dsq;
  always_comb begin
    dxa = DIFF_W'(diff(fld(ram_rdata, 3), fld(item, 3)));
    dya = DIFF_W'(diff(fld(ram_rdata, 4), fld(item, 4)));
    dza = DIFF_W'(diff(fld(ram_rdata, 5), fld(item, 5)));
    if (dxa[DIFF_W-1]) dxa = -dxa;
    if (dya[DIFF_W-1]) dya = -dya;
    if (dza[DIFF_W-1]) dza = -dza;
    qx = dxa * dxa;
    qy = dya * dya;
    qz = dza * dza;
    dsq = DIST_W'(qx) + DIST_W'(qy) + DIST_W'(qz);
  end

  // score unit: slot s scored against the other three in order
  logic sc_start, sc_done;
  logic [SCORE_W-1:0] sc_val;
  logic [AW-1:0] oa, ob, oc;
  logic [1:0] sc_out;
  always_comb begin
    unique case (sc_idx)
      2'd0: begin oa = AW'(1); ob = AW'(2); oc = AW'(3); end
      2'd1: begin oa = AW'(0); ob = AW'(2); oc = AW'(3); end
      2'd2: begin oa = AW'(0); ob = AW'(1); oc = AW'(3); end
      default: begin oa = AW'(0); ob = AW'(1); oc = AW'(2); end
    endcase
  end

  cmc_score u_score (
    .clk(clk), .start(sc_start),
    .ux(fld(item, 0)), .uy(fld(item, 1)), .uz(fld(item, 2)),
    .ax(fld(slots[oa], 0)), .ay(fld(slots[oa], 1)), .az(fld(slots[oa], 2)),
    .bx(fld(slots[ob], 0)), .by(fld(slots[ob], 1)), .bz(fld(slots[ob], 2)),
    .cx(fld(slots[oc], 0)), .cy(fld(slots[oc], 1)), .cz(fld(slots[oc], 2)),
    .done(sc_done), .score(sc_val)
  );
  assign sc_start = (state == S_SC_RD);

  // comparison tree over the four scores
  logic [2:0] pick;
  always_comb begin
    if (sc[0] < sc[1]) begin
      if (sc[1] < sc[2]) pick = (sc[2] < sc[3]) ? 3'd3 : 3'd2;
      else pick = (sc[1] < sc[3]) ? 3'd3 : 3'd1;
    end else if (sc[0] < sc[2]) begin
      pick = (sc[2] < sc[3]) ? 3'd3 : 3'd2;
    end else begin
      pick = (sc[0] < sc[3]) ? 3'd3 : 3'd0;
    end
  end

  // RAM control
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx;
    ram_wdata = item;
    ram_raddr = idx;
    if (state == S_MOVE_WR) begin
      ram_we = 1'b1;
      ram_waddr = evict[AW-1:0];
      ram_wdata = ram_rdata;
    end else if (state == S_APPEND) begin
      ram_we = 1'b1;
      ram_waddr = held_count[AW-1:0];
    end else if (state == S_MOVE_RD) begin
      ram_raddr = AW'(SLOTS - 1);
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {1'b0, held_count, evict, stored_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      persist_dist_sq <= DIST_RESET;
      held_count <= '0;
      evict <= SLOT_NONE;
      stored_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        persist_dist_sq <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            item <= s_tdata;
            evict <= SLOT_NONE;
            stored_r <= 1'b0;
            idx <= '0;
            if (s_tuser == REQ_CLEAR) begin
              held_count <= '0;
              state <= S_OUT;
            end else begin
              state <= (held_count == '0) ? S_APPEND : S_DUP_RD;
            end
          end
        end
        // read one held slot, check it next cycle
        S_DUP_RD: begin
          state <= S_DUP_CHK;
        end
        S_DUP_CHK: begin
          slots[idx] <= ram_rdata;
          if (dsq <= persist_dist_sq) begin
            state <= S_OUT;
          end else if (CW'(idx) + 1'b1 == held_count) begin
            if (held_count == CW'(SLOTS)) begin
              state <= S_DEPTH;
              best <= fld(item, 6);
              prot <= SLOT_NONE;
              idx <= '0;
            end else begin
              state <= S_APPEND;
            end
          end else begin
            idx <= idx + 1'b1;
            state <= S_DUP_RD;
          end
        end
        // find the protected slot, one slot a cycle
        S_DEPTH: begin
          if (fld(slots[idx], 6) > best) begin
            best <= fld(slots[idx], 6);
            prot <= 3'(idx);
          end
          if (idx == AW'(SLOTS - 1)) begin
            sc_idx <= '0;
            state <= S_SC_RD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // issue four scores back to back
        S_SC_RD: begin
          sc_out <= '0;
          if (sc_idx == 2'd3) state <= S_SC_WAIT;
          sc_idx <= sc_idx + 1'b1;
        end
        S_SC_WAIT: begin
          if (sc_done) begin
            sc[sc_out] <= (3'(sc_out) == prot) ? '0 : sc_val;
            sc_out <= sc_out + 1'b1;
            if (sc_out == 2'd3) state <= S_MOVE_RD;
          end
        end
        S_MOVE_RD: begin
          evict <= pick;
          held_count <= CW'(SLOTS - 1);
          state <= (pick == 3'(SLOTS - 1)) ? S_APPEND : S_MOVE_WR;
        end
        S_MOVE_WR: begin
          state <= S_APPEND;
        end
        S_APPEND: begin
          held_count <= held_count + 1'b1;
          stored_r <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // at most SLOTS points are ever held
  assert property (@(posedge clk) disable iff (rst) held_count <= CW'(SLOTS))
    else $error("held count overflow");
  // a stored result never reports an empty cache
  assert property (@(posedge clk) disable iff (rst) m_tvalid && stored_r |-> held_count != '0)
    else $error("stored with empty cache");
  // eviction only happens with a full cache
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && evict != SLOT_NONE |-> held_count == CW'(SLOTS) && stored_r)
    else $error("bad eviction");

endmodule
